// ===== rtl/acfp_pkg.sv =====
// Package for the ASCII command frame parser: widths, character codes, types.
package acfp_pkg;

    localparam int ByteW              = 8;
    localparam int MantW              = 50;
    localparam int ParamMantW         = 51;
    localparam int FracW              = 4;
    localparam int CfgAddrW           = 2;
    localparam int OutDataW           = 80;

    localparam int BufferBytesDefault = 128;
    localparam int ParamTextDefault   = 16;

    localparam logic [ByteW-1:0] CharUpperA = 8'h41;
    localparam logic [ByteW-1:0] CharUpperZ = 8'h5A;
    localparam logic [ByteW-1:0] CharPlus   = 8'h2B;
    localparam logic [ByteW-1:0] CharMinus  = 8'h2D;
    localparam logic [ByteW-1:0] CharDot    = 8'h2E;
    localparam logic [ByteW-1:0] CharZero   = 8'h30;
    localparam logic [ByteW-1:0] CharNine   = 8'h39;
    localparam logic [ByteW-1:0] CharNul    = 8'h00;

    localparam logic [ByteW-1:0] HeadReset     = 8'd35;
    localparam logic [ByteW-1:0] TailReset     = 8'd10;
    localparam logic [ByteW-1:0] OkReplyReset  = 8'd79;
    localparam logic [ByteW-1:0] ErrReplyReset = 8'd69;

    localparam logic [CfgAddrW-1:0] CfgHead     = 2'd0;
    localparam logic [CfgAddrW-1:0] CfgTail     = 2'd1;
    localparam logic [CfgAddrW-1:0] CfgOkReply  = 2'd2;
    localparam logic [CfgAddrW-1:0] CfgErrReply = 2'd3;

    typedef enum logic [5:0] {
        PhSearch = 6'b000001,
        PhLet1   = 6'b000010,
        PhLet2   = 6'b000100,
        PhText   = 6'b001000,
        PhOk     = 6'b010000,
        PhFail   = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [ByteW-1:0] head;
        logic [ByteW-1:0] tail;
        logic [ByteW-1:0] ok_reply;
        logic [ByteW-1:0] err_reply;
    } t_cfg;

    typedef struct packed {
        logic                  status;
        logic [ByteW-1:0]      reply_byte;
        logic [ByteW-1:0]      command_letter;
        logic [ByteW-1:0]      subcommand_letter;
        logic                  param_present;
        logic [ParamMantW-1:0] param_mantissa;
        logic [FracW-1:0]      param_frac_digits;
    } t_result;

endpackage

// ===== rtl/acfp_core.sv =====
// Frame parsing FSM: one byte a cycle while i_take is high; result forms on the last byte.
module acfp_core #(
    parameter int BUFFER_BYTES    = acfp_pkg::BufferBytesDefault,
    parameter int PARAM_TEXT_SIZE = acfp_pkg::ParamTextDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic [acfp_pkg::ByteW-1:0]   i_byte,
    input  logic                         i_last,
    input  acfp_pkg::t_cfg               i_cfg,
    output acfp_pkg::t_result            o_result
);

    localparam int CntW = $clog2(BUFFER_BYTES + 1);
    localparam int LenW = $clog2(PARAM_TEXT_SIZE);
    localparam logic [CntW-1:0] CntLimit = CntW'(BUFFER_BYTES);
    localparam logic [LenW-1:0] LenLimit = LenW'(PARAM_TEXT_SIZE - 1);

    acfp_pkg::t_phase r_phase, n_phase, s_phase;
    logic [CntW-1:0]                r_count, n_count, s_count;
    logic [acfp_pkg::ByteW-1:0]     r_first, n_first, s_first;
    logic [acfp_pkg::ByteW-1:0]     r_second, n_second, s_second;
    logic [LenW-1:0]                r_len, n_len, s_len;
    logic                           r_neg, n_neg, s_neg;
    logic                           r_digit, n_digit, s_digit;
    logic                           r_dot, n_dot, s_dot;
    logic                           r_end, n_end, s_end;
    logic                           r_bad, n_bad, s_bad;
    logic [acfp_pkg::MantW-1:0]     r_mant, n_mant, s_mant;
    logic [acfp_pkg::FracW-1:0]     r_frac, n_frac, s_frac;

    logic                           is_upper;
    logic                           is_digit;
    logic                           body_en;
    logic [acfp_pkg::ByteW-1:0]     digit_byte;
    logic [acfp_pkg::ParamMantW-1:0] mant_ext;

    assign is_upper   = (i_byte >= acfp_pkg::CharUpperA) && (i_byte <= acfp_pkg::CharUpperZ);
    assign is_digit   = (i_byte >= acfp_pkg::CharZero) && (i_byte <= acfp_pkg::CharNine);
    assign digit_byte = i_byte - acfp_pkg::CharZero;

    always_comb begin
        s_phase  = r_phase;
        s_count  = r_count;
        s_first  = r_first;
        s_second = r_second;
        s_len    = r_len;
        s_neg    = r_neg;
        s_digit  = r_digit;
        s_dot    = r_dot;
        s_end    = r_end;
        s_bad    = r_bad;
        s_mant   = r_mant;
        s_frac   = r_frac;
        body_en  = 1'b0;

        if (r_count < CntLimit) begin
            s_count = r_count + CntW'(1);
            unique case (r_phase)
                acfp_pkg::PhSearch: begin
                    if (i_byte == i_cfg.head) begin
                        s_phase = acfp_pkg::PhLet1;
                    end
                end
                acfp_pkg::PhLet1: begin
                    if (is_upper) begin
                        s_first = i_byte;
                        s_phase = acfp_pkg::PhLet2;
                    end else begin
                        s_phase = acfp_pkg::PhFail;
                    end
                end
                acfp_pkg::PhLet2: begin
                    if (is_upper) begin
                        s_second = i_byte;
                        s_phase  = acfp_pkg::PhText;
                    end else begin
                        s_phase = acfp_pkg::PhFail;
                    end
                end
                acfp_pkg::PhText: begin
                    if (i_byte == i_cfg.tail) begin
                        if (r_len == '0) begin
                            s_phase = acfp_pkg::PhOk;
                        end else if (r_bad || !r_digit) begin
                            s_phase = acfp_pkg::PhFail;
                        end else begin
                            s_phase = acfp_pkg::PhOk;
                        end
                    end else if (r_len >= LenLimit) begin
                        s_phase = acfp_pkg::PhFail;
                    end else begin
                        s_len = r_len + LenW'(1);
                        if (r_len == '0) begin
                            if (i_byte == acfp_pkg::CharNul) begin
                                s_bad = 1'b1;
                            end else if (i_byte == acfp_pkg::CharMinus) begin
                                s_neg = 1'b1;
                            end else if (i_byte != acfp_pkg::CharPlus) begin
                                body_en = 1'b1;
                            end
                        end else begin
                            body_en = 1'b1;
                        end
                    end
                end
                acfp_pkg::PhOk, acfp_pkg::PhFail: begin
                end
                default: begin
                end
            endcase
        end

        if (body_en && !r_end && !r_bad) begin
            if (i_byte == acfp_pkg::CharNul) begin
                s_end = 1'b1;
            end else if (is_digit) begin
                s_digit = 1'b1;
                s_mant  = (r_mant << 3) + (r_mant << 1)
                        + acfp_pkg::MantW'(digit_byte);
                if (r_dot) begin
                    s_frac = r_frac + acfp_pkg::FracW'(1);
                end
            end else if ((i_byte == acfp_pkg::CharDot) && !r_dot) begin
                s_dot = 1'b1;
            end else begin
                s_bad = 1'b1;
            end
        end
    end

    // A frame that ends well saw its tail on this or an earlier byte, so the
    // accumulated number is already final in the registers.
    assign mant_ext = {1'b0, r_mant};

    always_comb begin
        o_result = '0;
        if (s_phase == acfp_pkg::PhOk) begin
            o_result.status            = 1'b0;
            o_result.reply_byte        = i_cfg.ok_reply;
            o_result.command_letter    = s_first;
            o_result.subcommand_letter = s_second;
            if (r_len != '0) begin
                o_result.param_present     = 1'b1;
                o_result.param_mantissa    = r_neg ? (acfp_pkg::ParamMantW'(0) - mant_ext)
                                                   : mant_ext;
                o_result.param_frac_digits = r_frac;
            end
        end else begin
            o_result.status     = 1'b1;
            o_result.reply_byte = i_cfg.err_reply;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_first  = r_first;
        n_second = r_second;
        n_len    = r_len;
        n_neg    = r_neg;
        n_digit  = r_digit;
        n_dot    = r_dot;
        n_end    = r_end;
        n_bad    = r_bad;
        n_mant   = r_mant;
        n_frac   = r_frac;
        if (i_take) begin
            if (i_last) begin
                n_phase  = acfp_pkg::PhSearch;
                n_count  = '0;
                n_first  = '0;
                n_second = '0;
                n_len    = '0;
                n_neg    = 1'b0;
                n_digit  = 1'b0;
                n_dot    = 1'b0;
                n_end    = 1'b0;
                n_bad    = 1'b0;
                n_mant   = '0;
                n_frac   = '0;
            end else begin
                n_phase  = s_phase;
                n_count  = s_count;
                n_first  = s_first;
                n_second = s_second;
                n_len    = s_len;
                n_neg    = s_neg;
                n_digit  = s_digit;
                n_dot    = s_dot;
                n_end    = s_end;
                n_bad    = s_bad;
                n_mant   = s_mant;
                n_frac   = s_frac;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= acfp_pkg::PhSearch;
            r_count  <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_len    <= '0;
            r_neg    <= 1'b0;
            r_digit  <= 1'b0;
            r_dot    <= 1'b0;
            r_end    <= 1'b0;
            r_bad    <= 1'b0;
            r_mant   <= '0;
            r_frac   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_first  <= n_first;
            r_second <= n_second;
            r_len    <= n_len;
            r_neg    <= n_neg;
            r_digit  <= n_digit;
            r_dot    <= n_dot;
            r_end    <= n_end;
            r_bad    <= n_bad;
            r_mant   <= n_mant;
            r_frac   <= n_frac;
        end
    end

endmodule

// ===== rtl/ascii_command_frame_parser.sv =====
// Top level of the ASCII command frame parser: configuration registers and result buffer.
//
// The block takes the bytes of one receive buffer on the slave stream, one byte per
// beat, with tlast on the final byte of the buffer. Bytes up to the head character are
// skipped; two capital letters and an optional decimal parameter text follow, closed by
// the tail character. Exactly one result beat leaves on the master stream for every
// input beat that carries tlast: tuser is the status (0 frame accepted, 1 error or no
// frame) and tdata carries the reply byte, the letters and the parameter as an exact
// decimal (signed mantissa and count of fraction digits).
// Throughput is one input beat per cycle while tready is high; the parser state is updated
// in the cycle a beat is taken. The result of a last beat is registered and visible on the
// master side in the cycle after that beat is accepted when no earlier result is waiting.
// Results go into a two-entry buffer, so input beats keep flowing while one result waits
// to be taken; tready falls only when both entries are full, i.e. when the receiver has
// stalled on two results. Reset clears the parser to searching for a head, empties the
// buffer and loads the register defaults (head 35, tail 10, ok reply 79, error reply 69).
// Registers are written through the configuration port and are used from the next beat.
module ascii_command_frame_parser #(
    parameter int BUFFER_BYTES    = acfp_pkg::BufferBytesDefault,
    parameter int PARAM_TEXT_SIZE = acfp_pkg::ParamTextDefault
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [acfp_pkg::CfgAddrW-1:0]   i_cfg_addr,
    input  logic [acfp_pkg::ByteW-1:0]      i_cfg_wr_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [acfp_pkg::ByteW-1:0]      s_axis_tdata,    // [7:0] rx_byte
    input  logic                            s_axis_tlast,    // last_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] reply_byte, [15:8] command_letter, [23:16] subcommand_letter,
    // [24] param_present, [75:25] param_mantissa, [79:76] param_frac_digits
    output logic [acfp_pkg::OutDataW-1:0]   m_axis_tdata,
    output logic                            m_axis_tuser     // status
);

    acfp_pkg::t_cfg    r_cfg;
    acfp_pkg::t_result core_result;
    acfp_pkg::t_result r_out, r_skid;
    logic              r_out_valid, r_skid_valid;
    logic              take, push, pop;

    assign s_axis_tready = !r_skid_valid;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign push          = take && s_axis_tlast;
    assign pop           = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head      <= acfp_pkg::HeadReset;
            r_cfg.tail      <= acfp_pkg::TailReset;
            r_cfg.ok_reply  <= acfp_pkg::OkReplyReset;
            r_cfg.err_reply <= acfp_pkg::ErrReplyReset;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                acfp_pkg::CfgHead:     r_cfg.head      <= i_cfg_wr_data;
                acfp_pkg::CfgTail:     r_cfg.tail      <= i_cfg_wr_data;
                acfp_pkg::CfgOkReply:  r_cfg.ok_reply  <= i_cfg_wr_data;
                acfp_pkg::CfgErrReply: r_cfg.err_reply <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    acfp_core #(
        .BUFFER_BYTES    (BUFFER_BYTES),
        .PARAM_TEXT_SIZE (PARAM_TEXT_SIZE)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            r_out_valid  <= r_skid_valid || push;
            r_skid_valid <= r_skid_valid && push;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : core_result;
            if (r_skid_valid && push) begin
                r_skid <= core_result;
            end
        end else if (push) begin
            r_skid <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {r_out.param_frac_digits, r_out.param_mantissa, r_out.param_present,
                            r_out.subcommand_letter, r_out.command_letter, r_out.reply_byte};

endmodule

// ===== bench/testbench.sv =====
// Self-checking stream bench for the ASCII command frame parser, with a built-in frame predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RxBufferBytes  = acfp_pkg::BufferBytesDefault;
    localparam int ParamTextSize  = acfp_pkg::ParamTextDefault;
    localparam int SettleCycles   = 4;
    localparam int LongHoldCycles = 400;

    typedef struct packed {
        logic [acfp_pkg::ByteW-1:0] data;
        logic                       tlast;
    } t_rx_beat;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_wr_en   = 1'b0;
    logic [acfp_pkg::CfgAddrW-1:0] i_cfg_addr    = acfp_pkg::CfgHead;
    logic [acfp_pkg::ByteW-1:0]    i_cfg_wr_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [acfp_pkg::ByteW-1:0]    s_axis_tdata  = '0;
    logic                          s_axis_tlast  = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [acfp_pkg::OutDataW-1:0] m_axis_tdata;
    logic                          m_axis_tuser;

    ascii_command_frame_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    t_rx_beat          rx_beats[$];
    acfp_pkg::t_result pending_results[$];
    int       mismatches   = 0;
    int       rand_sent    = 0;
    logic     src_fire     = 1'b0;
    logic     quiet_tail   = 1'b0;
    int       src_gap      = 0;
    int       sink_gap     = 0;
    int       hold_left    = 0;
    int       holds_asked  = 0;
    int       holds_done   = 0;

    acfp_pkg::t_cfg             regs_now;
    acfp_pkg::t_phase           frame_ph;
    int                         rx_count;
    int                         text_len;
    logic [acfp_pkg::ByteW-1:0] cmd_a;
    logic [acfp_pkg::ByteW-1:0] cmd_b;
    logic                       neg_seen;
    logic                       digit_seen;
    logic                       dot_seen;
    logic                       text_ended;
    logic                       text_bad;
    logic [acfp_pkg::MantW-1:0] mant_acc;
    logic [acfp_pkg::FracW-1:0] frac_cnt;

    function automatic void reset_parse();
        frame_ph   = acfp_pkg::PhSearch;
        rx_count   = 0;
        text_len   = 0;
        cmd_a      = '0;
        cmd_b      = '0;
        neg_seen   = 1'b0;
        digit_seen = 1'b0;
        dot_seen   = 1'b0;
        text_ended = 1'b0;
        text_bad   = 1'b0;
        mant_acc   = '0;
        frac_cnt   = '0;
    endfunction

    function automatic logic is_capital(input logic [acfp_pkg::ByteW-1:0] c);
        return c >= acfp_pkg::CharUpperA && c <= acfp_pkg::CharUpperZ;
    endfunction

    function automatic void take_text_char(input logic [acfp_pkg::ByteW-1:0] c);
        if (text_len == 0 && c == acfp_pkg::CharNul) begin
            text_bad = 1'b1;
        end else if (text_len == 0 && c == acfp_pkg::CharPlus) begin
        end else if (text_len == 0 && c == acfp_pkg::CharMinus) begin
            neg_seen = 1'b1;
        end else if (text_ended || text_bad) begin
        end else if (c == acfp_pkg::CharNul) begin
            text_ended = 1'b1;
        end else if (c >= acfp_pkg::CharZero && c <= acfp_pkg::CharNine) begin
            digit_seen = 1'b1;
            mant_acc   = mant_acc * 10 + (c - acfp_pkg::CharZero);
            if (dot_seen) frac_cnt = frac_cnt + 1'b1;
        end else if (c == acfp_pkg::CharDot && !dot_seen) begin
            dot_seen = 1'b1;
        end else begin
            text_bad = 1'b1;
        end
        text_len++;
    endfunction

    function automatic void parse_rx_byte(input logic [acfp_pkg::ByteW-1:0] c);
        if (rx_count < RxBufferBytes) begin
            case (frame_ph)
                acfp_pkg::PhSearch: begin
                    if (c == regs_now.head) frame_ph = acfp_pkg::PhLet1;
                end
                acfp_pkg::PhLet1: begin
                    if (is_capital(c)) begin
                        cmd_a    = c;
                        frame_ph = acfp_pkg::PhLet2;
                    end else begin
                        frame_ph = acfp_pkg::PhFail;
                    end
                end
                acfp_pkg::PhLet2: begin
                    if (is_capital(c)) begin
                        cmd_b    = c;
                        frame_ph = acfp_pkg::PhText;
                    end else begin
                        frame_ph = acfp_pkg::PhFail;
                    end
                end
                acfp_pkg::PhText: begin
                    if (c == regs_now.tail) begin
                        if (text_len == 0 || (!text_bad && digit_seen)) begin
                            frame_ph = acfp_pkg::PhOk;
                        end else begin
                            frame_ph = acfp_pkg::PhFail;
                        end
                    end else if (text_len + 1 >= ParamTextSize) begin
                        frame_ph = acfp_pkg::PhFail;
                    end else begin
                        take_text_char(c);
                    end
                end
                default: begin
                end
            endcase
            rx_count++;
        end
    endfunction

    function automatic acfp_pkg::t_result close_buffer();
        acfp_pkg::t_result               r;
        logic [acfp_pkg::ParamMantW-1:0] m;
        r = '0;
        if (frame_ph == acfp_pkg::PhOk) begin
            r.reply_byte        = regs_now.ok_reply;
            r.command_letter    = cmd_a;
            r.subcommand_letter = cmd_b;
            if (text_len > 0) begin
                m                   = {1'b0, mant_acc};
                r.param_present     = 1'b1;
                r.param_mantissa    = neg_seen ? -m : m;
                r.param_frac_digits = frac_cnt;
            end
        end else begin
            r.status     = 1'b1;
            r.reply_byte = regs_now.err_reply;
        end
        reset_parse();
        return r;
    endfunction

    function automatic void check_field(input string fname, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        acfp_pkg::t_result want;
        src_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (src_fire) begin
            parse_rx_byte(s_axis_tdata);
            if (s_axis_tlast) pending_results.push_back(close_buffer());
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result beat expected none, got status %0b data %h",
                         $time, m_axis_tuser, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_axis_tuser);
                check_field("reply_byte", want.reply_byte, m_axis_tdata[7:0]);
                check_field("command_letter", want.command_letter, m_axis_tdata[15:8]);
                check_field("subcommand_letter", want.subcommand_letter, m_axis_tdata[23:16]);
                check_field("param_present", want.param_present, m_axis_tdata[24]);
                check_field("param_mantissa", want.param_mantissa, m_axis_tdata[75:25]);
                check_field("param_frac_digits", want.param_frac_digits, m_axis_tdata[79:76]);
            end
        end
    end

    always @(negedge i_clk) begin
        t_rx_beat nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || src_fire) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (rx_beats.size() > 0) begin
                nxt = rx_beats.pop_front();
                s_axis_tdata  <= nxt.data;
                s_axis_tlast  <= nxt.tlast;
                s_axis_tvalid <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 15);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = LongHoldCycles - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            sink_gap = $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic put(input logic [acfp_pkg::ByteW-1:0] b, input logic tl = 1'b0);
        t_rx_beat beat;
        beat.data  = b;
        beat.tlast = tl;
        rx_beats.push_back(beat);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    task automatic send_buffer(input logic [acfp_pkg::ByteW-1:0] seq[$]);
        foreach (seq[i]) put(seq[i], i == seq.size() - 1);
        rand_sent += seq.size();
    endtask

    task automatic write_reg(input logic [acfp_pkg::CfgAddrW-1:0] idx,
                             input logic [acfp_pkg::ByteW-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= idx;
        i_cfg_wr_data <= val;
        case (idx)
            acfp_pkg::CfgHead:     regs_now.head      = val;
            acfp_pkg::CfgTail:     regs_now.tail      = val;
            acfp_pkg::CfgOkReply:  regs_now.ok_reply  = val;
            acfp_pkg::CfgErrReply: regs_now.err_reply = val;
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (rx_beats.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    function automatic logic [acfp_pkg::ByteW-1:0] junk_byte();
        logic [acfp_pkg::ByteW-1:0] b;
        do b = 8'($urandom());
        while (b == regs_now.head);
        return b;
    endfunction

    function automatic logic [acfp_pkg::ByteW-1:0] rand_digit();
        return acfp_pkg::CharZero + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [acfp_pkg::ByteW-1:0] rand_letter();
        if ($urandom_range(0, 19) == 0) return 8'($urandom());
        return acfp_pkg::CharUpperA + 8'($urandom_range(0, 25));
    endfunction

    task automatic gen_buffer();
        logic [acfp_pkg::ByteW-1:0] seq[$];
        int               kind;
        int               variant;
        int               nsign;
        int               room;
        int               use_dot;
        int               ndig;
        int               dpos;
        kind = $urandom_range(0, 99);
        repeat ($urandom_range(0, 3)) seq.push_back(junk_byte());
        if (kind < 5) begin
            repeat ($urandom_range(1, 8)) seq.push_back(junk_byte());
        end else if (kind < 8) begin
            repeat ($urandom_range(1, 8)) seq.push_back(8'($urandom()));
        end else begin
            seq.push_back(regs_now.head);
            seq.push_back(rand_letter());
            seq.push_back(rand_letter());
            variant = $urandom_range(0, 19);
            case (variant)
                0: begin
                end
                1: repeat ($urandom_range(16, 19)) seq.push_back(rand_digit());
                2: begin
                    repeat ($urandom_range(1, 5)) seq.push_back(rand_digit());
                    seq.push_back(acfp_pkg::CharNul);
                    repeat ($urandom_range(0, 4)) seq.push_back(8'($urandom()));
                end
                3: seq.push_back(acfp_pkg::CharNul);
                4: begin
                    seq.push_back(rand_digit());
                    seq.push_back(8'($urandom()));
                    seq.push_back(rand_digit());
                end
                5: begin
                    seq.push_back(rand_digit());
                    seq.push_back(acfp_pkg::CharDot);
                    seq.push_back(rand_digit());
                    seq.push_back(acfp_pkg::CharDot);
                end
                6: seq.push_back($urandom_range(0, 1) ? acfp_pkg::CharMinus : acfp_pkg::CharDot);
                default: begin
                    nsign = $urandom_range(0, 2);
                    if (nsign == 1) seq.push_back(acfp_pkg::CharPlus);
                    else if (nsign == 2) seq.push_back(acfp_pkg::CharMinus);
                    room    = ParamTextSize - 1 - (nsign != 0);
                    use_dot = $urandom_range(0, 1);
                    if ($urandom_range(0, 3) == 0) ndig = $urandom_range(1, room - use_dot);
                    else ndig = $urandom_range(1, 4);
                    dpos = use_dot ? $urandom_range(0, ndig) : -1;
                    for (int k = 0; k < ndig; k++) begin
                        if (k == dpos) seq.push_back(acfp_pkg::CharDot);
                        seq.push_back(rand_digit());
                    end
                    if (dpos == ndig) seq.push_back(acfp_pkg::CharDot);
                end
            endcase
            if (kind >= 10) seq.push_back(regs_now.tail);
            repeat ($urandom_range(0, 2)) seq.push_back(8'($urandom()));
            if (kind == 99) repeat (RxBufferBytes) seq.push_back(8'($urandom()));
        end
        send_buffer(seq);
    endtask

    task automatic random_phase(input int nbytes);
        int start;
        start = rand_sent;
        while (rand_sent - start < nbytes) gen_buffer();
    endtask

    initial begin
        reset_parse();
        regs_now.head      = acfp_pkg::HeadReset;
        regs_now.tail      = acfp_pkg::TailReset;
        regs_now.ok_reply  = acfp_pkg::OkReplyReset;
        regs_now.err_reply = acfp_pkg::ErrReplyReset;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        put(regs_now.head); put_str("AZ"); put(regs_now.tail, 1'b1);
        put(acfp_pkg::CharNul); put(8'hFF);
        put(regs_now.head); put_str("MV-12.5"); put(regs_now.tail, 1'b1);
        put(regs_now.head); put_str("ZA999999999999999"); put(regs_now.tail, 1'b1);
        put(regs_now.head); put_str("AA.00000000000001"); put(regs_now.tail);
        put(regs_now.head); put_str("BB"); put(8'hFF, 1'b1);
        put(regs_now.head); put_str("QR+0.7"); put(regs_now.tail, 1'b1);
        put(regs_now.head); put_str("AB1234567890123456"); put(regs_now.tail, 1'b1);
        put(regs_now.head); put_str("CD42"); put(acfp_pkg::CharNul);
        put_str("?x"); put(regs_now.tail, 1'b1);
        put(regs_now.head); put_str("CD"); put(acfp_pkg::CharNul); put(regs_now.tail, 1'b1);
        put(regs_now.head); put_str("@B1"); put(regs_now.tail, 1'b1);
        put(regs_now.head); put_str("A[1"); put(regs_now.tail, 1'b1);
        put(regs_now.head); put_str("EF1.2.3"); put(regs_now.tail, 1'b1);
        put(regs_now.head); put_str("EF-"); put(regs_now.tail, 1'b1);
        put(regs_now.head); put_str("EF."); put(regs_now.tail, 1'b1);
        put(regs_now.head); put_str("EF1x"); put(regs_now.tail, 1'b1);
        put(regs_now.head); put_str("EF+-1"); put(regs_now.tail, 1'b1);
        put(regs_now.head); put_str("KL12."); put(regs_now.tail, 1'b1);
        put_str("abc"); put(8'h7F, 1'b1);
        put(regs_now.head); put_str("GH12"); put(acfp_pkg::CharNine, 1'b1);
        put(regs_now.head, 1'b1);
        put(8'hFF, 1'b1);
        put(regs_now.head); put_str("A"); put(regs_now.tail, 1'b1);
        // The tail lands on the final counted byte; later bytes and the last flag lie beyond.
        repeat (RxBufferBytes - 5) put(8'h20);
        put(regs_now.head); put_str("AB5"); put(regs_now.tail);
        repeat (3) put(8'hA5);
        put(acfp_pkg::CharNul, 1'b1);
        repeat (RxBufferBytes - 4) put(8'h20);
        put(regs_now.head); put_str("AB5"); put(regs_now.tail, 1'b1);

        // A buffer left open across a register write: the new tail closes it.
        settle();
        put(regs_now.head); put_str("AB1");
        settle();
        write_reg(acfp_pkg::CfgTail, 8'h3B);
        put_str("2"); put(8'h3B, 1'b1);

        settle();
        write_reg(acfp_pkg::CfgHead, 8'h00);
        write_reg(acfp_pkg::CfgTail, 8'hFF);
        write_reg(acfp_pkg::CfgOkReply, 8'h00);
        write_reg(acfp_pkg::CfgErrReply, 8'hFF);
        random_phase(20);

        settle();
        write_reg(acfp_pkg::CfgHead, 8'hFF);
        write_reg(acfp_pkg::CfgTail, 8'h00);
        write_reg(acfp_pkg::CfgOkReply, 8'hFF);
        write_reg(acfp_pkg::CfgErrReply, 8'h00);
        random_phase(20);

        // The receiver stalls for a long stretch while beats keep arriving.
        settle();
        holds_asked++;
        random_phase(40);

        settle();
        write_reg(acfp_pkg::CfgHead, 8'($urandom()));
        write_reg(acfp_pkg::CfgTail, 8'($urandom()));
        write_reg(acfp_pkg::CfgOkReply, 8'($urandom()));
        write_reg(acfp_pkg::CfgErrReply, 8'($urandom()));
        random_phase(20);

        settle();
        write_reg(acfp_pkg::CfgHead, acfp_pkg::HeadReset);
        write_reg(acfp_pkg::CfgTail, acfp_pkg::TailReset);
        write_reg(acfp_pkg::CfgOkReply, acfp_pkg::OkReplyReset);
        write_reg(acfp_pkg::CfgErrReply, acfp_pkg::ErrReplyReset);
        quiet_tail = 1'b1;
        random_phase(20);

        settle();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/acfp_pkg.sv
rtl/acfp_core.sv
rtl/ascii_command_frame_parser.sv
bench/testbench.sv
